[src/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and defaults for the sorted chunk table.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned DefCapacity   = 256;
  localparam int unsigned DefAddrBits   = 32;
  localparam int unsigned DefSizeBits   = 32;
  localparam logic [8:0]  LimitResetVal = 9'd256;

  typedef enum logic [2:0] {
    CMD_FIRST_FIT = 3'd0,
    CMD_FIND      = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_COALESCE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_REMOVE,
    S_COAL,
    S_FLUSH,
    S_DONE
  } state_e;

endpackage

[src/sct_ram.sv]
// ----------------------------------------------------------------------------
// sct_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sct_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/sorted_chunk_table.sv]
// ----------------------------------------------------------------------------
// sorted_chunk_table
// Address-ordered chunk table with first fit, find, insert, remove, coalesce.
// ----------------------------------------------------------------------------
// One command is worked at a time; entries live in one RAM (start, size) with
// a registered read, walked at one entry per clock. First fit and find walk
// up to the matched index; insert shifts up the entries above the new one;
// remove shifts down the entries after the removed one; coalesce walks every
// entry. All of these walks go through the single RAM read port.
// A result waits in the output register while the next request is accepted.
module sorted_chunk_table
  import sct_pkg::*;
#(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned ADDR_BITS = DefAddrBits,
  parameter int unsigned SIZE_BITS = DefSizeBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] chunk_start_i,
  input  logic [31:0] chunk_size_i,
  input  logic [7:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  result_index_o,
  output logic [31:0] result_start_o,
  output logic [31:0] result_size_o,
  output logic [8:0]  entry_count_o
);

  localparam int unsigned IW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned XW  = (CW > 9) ? CW : 9;
  localparam int unsigned DW  = ADDR_BITS + SIZE_BITS;
  localparam int unsigned AXW = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam int unsigned SXW = (SIZE_BITS > 32) ? SIZE_BITS : 32;
  localparam int unsigned MW  = (ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [ADDR_BITS-1:0] st_q, st_d;
  logic [SIZE_BITS-1:0] sz_q, sz_d;
  logic [CW-1:0]        count_q, count_d;
  logic [8:0]           limit_q;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        w_q, w_d;
  logic                 pend_q, pend_d;
  logic                 first_q, first_d;
  logic                 have_q, have_d;
  logic [ADDR_BITS-1:0] cur_st_q, cur_st_d;
  logic [SIZE_BITS-1:0] cur_sz_q, cur_sz_d;

  status_e              rs_status_q, rs_status_d;
  logic [CW-1:0]        rs_idx_q, rs_idx_d;
  logic [ADDR_BITS-1:0] rs_st_q, rs_st_d;
  logic [SIZE_BITS-1:0] rs_sz_q, rs_sz_d;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [XW-1:0]        out_idx_q;
  logic [AXW-1:0]       out_st_q;
  logic [SXW-1:0]       out_sz_q;
  logic [XW-1:0]        out_cnt_q;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0] r_st;
  logic [SIZE_BITS-1:0] r_sz;

  logic [AXW-1:0]       in_st_x;
  logic [SXW-1:0]       in_sz_x;
  logic [ADDR_BITS-1:0] in_st;
  logic [SIZE_BITS-1:0] in_sz;
  logic                 accept, load_out;
  logic [CW-1:0]        cm1;
  logic [ADDR_BITS-1:0] gap;
  logic                 adj;
  logic [SIZE_BITS:0]   sum;
  logic [SIZE_BITS-1:0] sat_sz;

  sct_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign r_st    = ram_rdata[DW-1:SIZE_BITS];
  assign r_sz    = ram_rdata[SIZE_BITS-1:0];
  assign in_st_x = AXW'(chunk_start_i);
  assign in_sz_x = SXW'(chunk_size_i);
  assign in_st   = in_st_x[ADDR_BITS-1:0];
  assign in_sz   = in_sz_x[SIZE_BITS-1:0];
  assign accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cm1     = count_q - CW'(1);

  assign gap    = r_st - cur_st_q;
  assign adj    = have_q && (r_st >= cur_st_q) && (MW'(gap) == MW'(cur_sz_q));
  assign sum    = {1'b0, cur_sz_q} + {1'b0, r_sz};
  assign sat_sz = sum[SIZE_BITS] ? '1 : sum[SIZE_BITS-1:0];

  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    st_d        = st_q;
    sz_d        = sz_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    w_d         = w_q;
    pend_d      = pend_q;
    first_d     = first_q;
    have_d      = have_q;
    cur_st_d    = cur_st_q;
    cur_sz_d    = cur_sz_q;
    rs_status_d = rs_status_q;
    rs_idx_d    = rs_idx_q;
    rs_st_d     = rs_st_q;
    rs_sz_d     = rs_sz_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[IW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d       = cmd_e'(command_i);
          st_d        = in_st;
          sz_d        = in_sz;
          rs_status_d = STS_OK;
          rs_idx_d    = '0;
          rs_st_d     = '0;
          rs_sz_d     = '0;
          state_d     = S_DONE;
          unique case (command_i)
            CMD_FIRST_FIT, CMD_FIND: begin
              if (count_q == '0) begin
                rs_status_d = STS_NOT_FOUND;
              end else begin
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            CMD_INSERT: begin
              if (XW'(count_q) >= XW'(limit_q) || count_q >= CW'(CAPACITY)) begin
                rs_status_d = STS_FULL;
              end else begin
                ptr_d     = count_q;
                pend_d    = (count_q != '0);
                ram_raddr = cm1[IW-1:0];
                state_d   = S_INSERT;
              end
            end
            CMD_REMOVE: begin
              if (XW'(entry_index_i) >= XW'(count_q)) begin
                rs_status_d = STS_BAD_INDEX;
              end else begin
                ptr_d     = CW'(entry_index_i);
                ram_raddr = IW'(entry_index_i);
                first_d   = 1'b1;
                state_d   = S_REMOVE;
              end
            end
            CMD_COALESCE: begin
              if (count_q != '0) begin
                ptr_d   = '0;
                w_d     = '0;
                have_d  = 1'b0;
                state_d = S_COAL;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if ((cmd_q == CMD_FIRST_FIT) ? (r_sz >= sz_q) : (r_st == st_q)) begin
          rs_idx_d = ptr_q;
          rs_st_d  = r_st;
          rs_sz_d  = r_sz;
          state_d  = S_DONE;
        end else if (ptr_q == cm1) begin
          rs_status_d = STS_NOT_FOUND;
          state_d     = S_DONE;
        end else begin
          ptr_d     = ptr_q + CW'(1);
          ram_raddr = ptr_d[IW-1:0];
        end
      end

      S_INSERT: begin
        ram_we = 1'b1;
        if (pend_q && (st_q < r_st)) begin
          ptr_d     = ptr_q - CW'(1);
          pend_d    = (ptr_d != '0);
          ram_raddr = ptr_q[IW-1:0] - IW'(2);
        end else begin
          ram_wdata = {st_q, sz_q};
          count_d   = count_q + CW'(1);
          rs_idx_d  = ptr_q;
          rs_st_d   = st_q;
          rs_sz_d   = sz_q;
          state_d   = S_DONE;
        end
      end

      S_REMOVE: begin
        first_d = 1'b0;
        if (first_q) begin
          rs_idx_d = ptr_q;
          rs_st_d  = r_st;
          rs_sz_d  = r_sz;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q[IW-1:0] - IW'(1);
        end
        if (ptr_q == cm1) begin
          count_d = cm1;
          state_d = S_DONE;
        end else begin
          ptr_d     = ptr_q + CW'(1);
          ram_raddr = ptr_d[IW-1:0];
        end
      end

      S_COAL: begin
        ram_waddr = w_q[IW-1:0];
        ram_wdata = {cur_st_q, cur_sz_q};
        if (adj) begin
          cur_sz_d = sat_sz;
        end else begin
          if (have_q) begin
            ram_we = 1'b1;
            w_d    = w_q + CW'(1);
          end
          cur_st_d = r_st;
          cur_sz_d = r_sz;
          have_d   = 1'b1;
        end
        if (ptr_q == cm1) begin
          state_d = S_FLUSH;
        end else begin
          ptr_d     = ptr_q + CW'(1);
          ram_raddr = ptr_d[IW-1:0];
        end
      end

      S_FLUSH: begin
        ram_we    = 1'b1;
        ram_waddr = w_q[IW-1:0];
        ram_wdata = {cur_st_q, cur_sz_q};
        count_d   = w_q + CW'(1);
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      limit_q     <= LimitResetVal;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      have_q  <= have_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    st_q        <= st_d;
    sz_q        <= sz_d;
    ptr_q       <= ptr_d;
    w_q         <= w_d;
    cur_st_q    <= cur_st_d;
    cur_sz_q    <= cur_sz_d;
    rs_status_q <= rs_status_d;
    rs_idx_q    <= rs_idx_d;
    rs_st_q     <= rs_st_d;
    rs_sz_q     <= rs_sz_d;
    if (load_out) begin
      out_status_q <= rs_status_q;
      out_idx_q    <= XW'(rs_idx_q);
      out_st_q     <= AXW'(rs_st_q);
      out_sz_q     <= SXW'(rs_sz_q);
      out_cnt_q    <= XW'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_index_o = out_idx_q[7:0];
  assign result_start_o = out_st_q[31:0];
  assign result_size_o  = out_sz_q[31:0];
  assign entry_count_o  = out_cnt_q[8:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted request did not start work");

  a_done_hand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == S_IDLE)
    else $error("result not handed to output register");

  a_coal_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH |=> count_q <= $past(count_q))
    else $error("coalesce grew the table");

endmodule
